>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scp assertion failed");

// next-cycle implication
`define SCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scp assertion failed");

`endif

>>> rtl/core/scp_pkg.sv
// shared widths, beat types and sign helpers for segment_crossing_point
// no dependencies
package scp_pkg;

	localparam int CoordBits = 16;
	localparam int LimitW    = 16;

	localparam int DiffW  = CoordBits + 1;
	localparam int ProdW  = 2 * DiffW;
	localparam int SideW  = ProdW + 1;
	localparam int CProdW = 2 * CoordBits;
	localparam int DetW   = CProdW + 1;
	localparam int NProdW = DetW + DiffW;
	localparam int NumW   = NProdW + 1;
	localparam int DenW   = SideW;
	localparam int CmpW   = (NumW > DenW + CoordBits) ? NumW : DenW + CoordBits;
	localparam int HalfW  = NumW + 1;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffW-1:0]     diff_t;
	typedef logic signed [ProdW-1:0]     prod_t;
	typedef logic signed [SideW-1:0]     side_t;
	typedef logic signed [CProdW-1:0]    cprod_t;
	typedef logic signed [DetW-1:0]      det_t;
	typedef logic signed [NProdW-1:0]    nprod_t;
	typedef logic signed [NumW-1:0]      num_t;
	typedef logic [NumW-1:0]             mag_t;
	typedef logic [DenW-1:0]             den_t;
	typedef logic [CoordBits-1:0]        quo_t;
	typedef logic [CoordBits:0]          rnd_t;
	typedef logic [LimitW-1:0]           limit_t;

	localparam limit_t LimitReset = limit_t'(1);
	localparam coord_t CoordMax   = {1'b0, {(CoordBits-1){1'b1}}};
	localparam coord_t CoordMin   = {1'b1, {(CoordBits-1){1'b0}}};
	localparam rnd_t   SatPosMag  = {2'b00, {(CoordBits-1){1'b1}}};
	localparam rnd_t   SatNegMag  = {2'b01, {(CoordBits-1){1'b0}}};

	typedef struct packed {
		coord_t seg_a_x;
		coord_t seg_a_y;
		coord_t seg_b_x;
		coord_t seg_b_y;
		coord_t step_c_x;
		coord_t step_c_y;
		coord_t step_d_x;
		coord_t step_d_y;
	} in_t;

	typedef struct packed {
		logic   crosses;
		coord_t cross_x;
		coord_t cross_y;
	} out_t;

	typedef struct packed {
		mag_t   nx;
		mag_t   ny;
		logic   negx;
		logic   negy;
		den_t   den;
		logic   live;
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} front_t;

	typedef struct packed {
		mag_t rem;
		quo_t quo;
		logic neg;
		logic over;
	} div_lane_t;

	typedef struct packed {
		div_lane_t x;
		div_lane_t y;
		den_t      den;
		logic      live;
		coord_t    ax;
		coord_t    ay;
		coord_t    bx;
		coord_t    by;
	} div_stage_t;

	function automatic logic side_neg(side_t v);
		return v[SideW-1];
	endfunction

	function automatic logic side_pos(side_t v);
		return !v[SideW-1] && (v != '0);
	endfunction

endpackage

>>> rtl/core/scp_front.sv
// cross products, denominator, numerators and magnitudes in six stages
// depends on scp_pkg
module scp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  scp_pkg::in_t     up_data,
	input  scp_pkg::limit_t  limit,
	output logic             dn_valid,
	input  logic             dn_ready,
	output scp_pkg::front_t  dn_data
);
	import scp_pkg::*;

	localparam int Stages = 6;

	logic [Stages-1:0] vld_q;
	logic              adv;

	in_t    pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;
	diff_t  abx_s1, aby_s1, cax_s1, cay_s1, dax_s1, day_s1, dcx_s1, dcy_s1;
	diff_t  abx_s2, aby_s2, dcx_s2, dcy_s2;
	diff_t  abx_s3, aby_s3, dcx_s3, dcy_s3;
	prod_t  pc1_s2, pc2_s2, pd1_s2, pd2_s2, pn1_s2, pn2_s2;
	cprod_t pab1_s2, pab2_s2, pcd1_s2, pcd2_s2;
	side_t  side_c_s3, side_d_s3, den_s3;
	det_t   dab_s3, dcd_s3;
	logic   opp_s4, den_neg_s4, den_neg_s5, live_s5;
	den_t   dmag_s4, dmag_s5;
	nprod_t mx1_s4, mx2_s4, my1_s4, my2_s4;
	num_t   numx_s5, numy_s5;
	front_t fr_s6;

	assign adv      = !vld_q[Stages-1] || dn_ready;
	assign up_ready = adv;
	assign dn_valid = vld_q[Stages-1];
	assign dn_data  = fr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Stages-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// differences
			pt_s1  <= up_data;
			abx_s1 <= DiffW'(up_data.seg_b_x) - DiffW'(up_data.seg_a_x);
			aby_s1 <= DiffW'(up_data.seg_b_y) - DiffW'(up_data.seg_a_y);
			cax_s1 <= DiffW'(up_data.step_c_x) - DiffW'(up_data.seg_a_x);
			cay_s1 <= DiffW'(up_data.step_c_y) - DiffW'(up_data.seg_a_y);
			dax_s1 <= DiffW'(up_data.step_d_x) - DiffW'(up_data.seg_a_x);
			day_s1 <= DiffW'(up_data.step_d_y) - DiffW'(up_data.seg_a_y);
			dcx_s1 <= DiffW'(up_data.step_d_x) - DiffW'(up_data.step_c_x);
			dcy_s1 <= DiffW'(up_data.step_d_y) - DiffW'(up_data.step_c_y);

			// products
			pc1_s2  <= ProdW'(abx_s1) * ProdW'(cay_s1);
			pc2_s2  <= ProdW'(aby_s1) * ProdW'(cax_s1);
			pd1_s2  <= ProdW'(abx_s1) * ProdW'(day_s1);
			pd2_s2  <= ProdW'(aby_s1) * ProdW'(dax_s1);
			pn1_s2  <= ProdW'(abx_s1) * ProdW'(dcy_s1);
			pn2_s2  <= ProdW'(aby_s1) * ProdW'(dcx_s1);
			pab1_s2 <= CProdW'(pt_s1.seg_a_x) * CProdW'(pt_s1.seg_b_y);
			pab2_s2 <= CProdW'(pt_s1.seg_a_y) * CProdW'(pt_s1.seg_b_x);
			pcd1_s2 <= CProdW'(pt_s1.step_c_x) * CProdW'(pt_s1.step_d_y);
			pcd2_s2 <= CProdW'(pt_s1.step_c_y) * CProdW'(pt_s1.step_d_x);
			pt_s2   <= pt_s1;
			abx_s2  <= abx_s1;
			aby_s2  <= aby_s1;
			dcx_s2  <= dcx_s1;
			dcy_s2  <= dcy_s1;

			// sides, denominator, line determinants
			side_c_s3 <= SideW'(pc1_s2) - SideW'(pc2_s2);
			side_d_s3 <= SideW'(pd1_s2) - SideW'(pd2_s2);
			den_s3    <= SideW'(pn1_s2) - SideW'(pn2_s2);
			dab_s3    <= DetW'(pab1_s2) - DetW'(pab2_s2);
			dcd_s3    <= DetW'(pcd1_s2) - DetW'(pcd2_s2);
			pt_s3     <= pt_s2;
			abx_s3    <= abx_s2;
			aby_s3    <= aby_s2;
			dcx_s3    <= dcx_s2;
			dcy_s3    <= dcy_s2;

			// side test, denominator magnitude, numerator products
			opp_s4     <= (side_neg(side_c_s3) && side_pos(side_d_s3)) ||
				(side_pos(side_c_s3) && side_neg(side_d_s3));
			den_neg_s4 <= den_s3[SideW-1];
			dmag_s4    <= den_s3[SideW-1] ? $unsigned(-den_s3) : $unsigned(den_s3);
			mx1_s4     <= NProdW'(dcd_s3) * NProdW'(abx_s3);
			mx2_s4     <= NProdW'(dab_s3) * NProdW'(dcx_s3);
			my1_s4     <= NProdW'(dcd_s3) * NProdW'(aby_s3);
			my2_s4     <= NProdW'(dab_s3) * NProdW'(dcy_s3);
			pt_s4      <= pt_s3;

			// numerators, parallel test
			numx_s5    <= NumW'(mx1_s4) - NumW'(mx2_s4);
			numy_s5    <= NumW'(my1_s4) - NumW'(my2_s4);
			live_s5    <= opp_s4 && (dmag_s4 > DenW'(limit));
			den_neg_s5 <= den_neg_s4;
			dmag_s5    <= dmag_s4;
			pt_s5      <= pt_s4;

			// magnitudes and quotient signs
			fr_s6.nx   <= numx_s5[NumW-1] ? $unsigned(-numx_s5) : $unsigned(numx_s5);
			fr_s6.ny   <= numy_s5[NumW-1] ? $unsigned(-numy_s5) : $unsigned(numy_s5);
			fr_s6.negx <= numx_s5[NumW-1] ^ den_neg_s5;
			fr_s6.negy <= numy_s5[NumW-1] ^ den_neg_s5;
			fr_s6.den  <= dmag_s5;
			fr_s6.live <= live_s5;
			fr_s6.ax   <= pt_s5.seg_a_x;
			fr_s6.ay   <= pt_s5.seg_a_y;
			fr_s6.bx   <= pt_s5.seg_b_x;
			fr_s6.by   <= pt_s5.seg_b_y;
		end
	end

endmodule

>>> rtl/core/scp_divider.sv
// pipelined restoring divider for both point coordinates, one quotient bit a stage
// depends on scp_pkg
module scp_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  scp_pkg::front_t     up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output scp_pkg::div_stage_t dn_data
);
	import scp_pkg::*;

	localparam int Stages = CoordBits + 1;

	logic [Stages-1:0] vld_q;
	logic              adv;
	div_stage_t        head;
	div_stage_t        stg_s [Stages];
	div_stage_t        nxt [1:Stages-1];

	function automatic div_lane_t lane_step(div_lane_t l, logic [CmpW-1:0] dsh, quo_t bitm);
		div_lane_t o;
		o = l;
		if (CmpW'(l.rem) >= dsh) begin
			o.rem = l.rem - NumW'(dsh);
			o.quo = l.quo | bitm;
		end
		return o;
	endfunction

	function automatic div_stage_t stage_step(div_stage_t s, logic [CmpW-1:0] dsh,
		quo_t bitm);
		div_stage_t o;
		o   = s;
		o.x = lane_step(s.x, dsh, bitm);
		o.y = lane_step(s.y, dsh, bitm);
		return o;
	endfunction

	assign adv      = !vld_q[Stages-1] || dn_ready;
	assign up_ready = adv;
	assign dn_valid = vld_q[Stages-1];
	assign dn_data  = stg_s[Stages-1];

	// quotient at or above full coordinate range saturates
	always_comb begin
		head.x.rem  = up_data.nx;
		head.x.quo  = '0;
		head.x.neg  = up_data.negx;
		head.x.over = CmpW'(up_data.nx) >= (CmpW'(up_data.den) << CoordBits);
		head.y.rem  = up_data.ny;
		head.y.quo  = '0;
		head.y.neg  = up_data.negy;
		head.y.over = CmpW'(up_data.ny) >= (CmpW'(up_data.den) << CoordBits);
		head.den    = up_data.den;
		head.live   = up_data.live;
		head.ax     = up_data.ax;
		head.ay     = up_data.ay;
		head.bx     = up_data.bx;
		head.by     = up_data.by;
	end

	for (genvar k = 1; k < Stages; k++) begin : g_bit
		localparam int Bit = Stages - 1 - k;
		assign nxt[k] = stage_step(stg_s[k-1], CmpW'(stg_s[k-1].den) << Bit,
			quo_t'(1) << Bit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Stages-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0] <= head;
			for (int k = 1; k < Stages; k++) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

endmodule

>>> rtl/core/scp_back.sv
// rounding, saturation, strict inside tests and output register
// depends on scp_pkg
module scp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  scp_pkg::div_stage_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output scp_pkg::out_t       dn_data
);
	import scp_pkg::*;

	localparam int Stages = 4;

	logic [Stages-1:0] vld_q;
	logic              adv;

	div_stage_t dv_s1, dv_s2;
	logic       hx_s1, hy_s1;
	coord_t     px_s2, py_s2, px_s3, py_s3;
	logic       live_s3;
	prod_t      e1_s3, e2_s3, f1_s3, f2_s3;
	out_t       res_s4;

	diff_t  pax, pay, pbx, pby, abx, aby;
	side_t  dot_a, dot_b;
	logic   hit;

	function automatic coord_t sat_round(quo_t quo, logic half, logic neg, logic over);
		rnd_t   q1;
		rnd_t   qn;
		coord_t res;
		q1 = rnd_t'(quo) + rnd_t'(half);
		qn = rnd_t'(0) - q1;
		if (neg) begin
			res = (over || q1 > SatNegMag) ? CoordMin : qn[CoordBits-1:0];
		end else begin
			res = (over || q1 > SatPosMag) ? CoordMax : q1[CoordBits-1:0];
		end
		return res;
	endfunction

	assign adv      = !vld_q[Stages-1] || dn_ready;
	assign up_ready = adv;
	assign dn_valid = vld_q[Stages-1];
	assign dn_data  = res_s4;

	assign pax = DiffW'(px_s2) - DiffW'(dv_s2.ax);
	assign pay = DiffW'(py_s2) - DiffW'(dv_s2.ay);
	assign pbx = DiffW'(px_s2) - DiffW'(dv_s2.bx);
	assign pby = DiffW'(py_s2) - DiffW'(dv_s2.by);
	assign abx = DiffW'(dv_s2.bx) - DiffW'(dv_s2.ax);
	assign aby = DiffW'(dv_s2.by) - DiffW'(dv_s2.ay);

	assign dot_a = SideW'(e1_s3) + SideW'(e2_s3);
	assign dot_b = SideW'(f1_s3) + SideW'(f2_s3);
	assign hit   = live_s3 && side_pos(dot_a) && side_pos(dot_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Stages-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// round half up on the remainder
			dv_s1 <= up_data;
			hx_s1 <= (HalfW'(up_data.x.rem) << 1) >= HalfW'(up_data.den);
			hy_s1 <= (HalfW'(up_data.y.rem) << 1) >= HalfW'(up_data.den);

			// signed point, saturated
			px_s2 <= sat_round(dv_s1.x.quo, hx_s1, dv_s1.x.neg, dv_s1.x.over);
			py_s2 <= sat_round(dv_s1.y.quo, hy_s1, dv_s1.y.neg, dv_s1.y.over);
			dv_s2 <= dv_s1;

			// dot product terms
			e1_s3   <= ProdW'(pax) * ProdW'(abx);
			e2_s3   <= ProdW'(pay) * ProdW'(aby);
			f1_s3   <= ProdW'(pbx) * ProdW'(-abx);
			f2_s3   <= ProdW'(pby) * ProdW'(-aby);
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			live_s3 <= dv_s2.live;

			res_s4.crosses <= hit;
			res_s4.cross_x <= hit ? px_s3 : '0;
			res_s4.cross_y <= hit ? py_s3 : '0;
		end
	end

endmodule

>>> rtl/core/segment_crossing_point.sv
// segment_crossing_point: step versus segment crossing test with crossing point
// top level, depends on scp_pkg, scp_front, scp_divider, scp_back, assert_macros.svh
//
// item channel: item_valid, item_ready, item_data carries segment a-b and step c-d
// result channel: result_valid, result_ready, result_data gives crosses and the point
// cfg channel: cfg_valid, cfg_ready, cfg_data writes near_zero_limit, always ready,
//   change it only while no items are in flight
// one result beat per item beat, in order
// pipeline: 6 stages of differences, products and magnitudes, CoordBits + 1 divider
//   stages (one quotient bit per stage for both coordinates), 4 stages of rounding,
//   saturation and inside tests ending in the output register
// throughput: one item per cycle while each section's last stage can move on
// receiver stall: each of the three sections holds all its stages while its last stage
//   is full and not taken; earlier sections keep advancing while their last is empty
// reset: all stages empty, near_zero_limit back to 1
`include "assert_macros.svh"

module segment_crossing_point (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  scp_pkg::in_t     item_data,
	output logic             result_valid,
	input  logic             result_ready,
	output scp_pkg::out_t    result_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  scp_pkg::limit_t  cfg_data
);
	import scp_pkg::*;

	limit_t     near_zero_limit_q;
	logic       fr_valid, fr_ready;
	front_t     fr_data;
	logic       dv_valid, dv_ready;
	div_stage_t dv_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_zero_limit_q <= LimitReset;
		end else if (cfg_valid && cfg_ready) begin
			near_zero_limit_q <= cfg_data;
		end
	end

	scp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.up_data  (item_data),
		.limit    (near_zero_limit_q),
		.dn_valid (fr_valid),
		.dn_ready (fr_ready),
		.dn_data  (fr_data)
	);

	scp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fr_valid),
		.up_ready (fr_ready),
		.up_data  (fr_data),
		.dn_valid (dv_valid),
		.dn_ready (dv_ready),
		.dn_data  (dv_data)
	);

	scp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dv_valid),
		.up_ready (dv_ready),
		.up_data  (dv_data),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_data  (result_data)
	);

	`SCP_ASSERT_IMPL(a_zero_on_miss, result_valid && !result_data.crosses, result_data.cross_x == '0 && result_data.cross_y == '0)
	`SCP_ASSERT_NEXT(a_limit_write, cfg_valid && cfg_ready, near_zero_limit_q == $past(cfg_data))
	`SCP_ASSERT_IMPL(a_ready_when_drained, !result_valid, item_ready)

endmodule
